>>> rtl/ami_pkg.sv
// Shared constants for the affine matrix inverse pipeline.
`default_nettype none
package ami_pkg;
    localparam int DEF_WORD_BITS = 32;
    localparam int DEF_FRAC_BITS = 16;
    localparam int N_FIELDS      = 12;
    localparam int N_DIM         = 3;
    localparam int THR_DEN       = 10000;
    localparam int FRONT_STAGES  = 3;
    localparam int BACK_STAGES   = 3;
endpackage
`default_nettype wire

>>> rtl/ami_front.sv
// Front stages: sign/magnitude split, column squares, squared norms and threshold test.
`default_nettype none
module ami_front #(
    parameter int WORD_BITS = ami_pkg::DEF_WORD_BITS,
    parameter int FRAC_BITS = ami_pkg::DEF_FRAC_BITS
) (
    input  wire logic                                     aclk,
    input  wire logic [ami_pkg::FRONT_STAGES-1:0]         ld,
    input  wire logic [ami_pkg::N_FIELDS*WORD_BITS-1:0]   in_data,
    output logic                                          neg_o  [ami_pkg::N_FIELDS],
    output logic [WORD_BITS-1:0]                          mag_o  [ami_pkg::N_FIELDS],
    output logic [2*WORD_BITS-1:0]                        norm_o [ami_pkg::N_DIM],
    output logic                                          ok_o
);
    localparam int NORM_W = 2*WORD_BITS;
    localparam logic [NORM_W-1:0] THR =
        NORM_W'((130'(1) << (2*FRAC_BITS)) / 130'(ami_pkg::THR_DEN));

    logic                 neg0_reg [ami_pkg::N_FIELDS];
    logic [WORD_BITS-1:0] mag0_reg [ami_pkg::N_FIELDS];
    logic                 neg1_reg [ami_pkg::N_FIELDS];
    logic [WORD_BITS-1:0] mag1_reg [ami_pkg::N_FIELDS];
    logic                 neg2_reg [ami_pkg::N_FIELDS];
    logic [WORD_BITS-1:0] mag2_reg [ami_pkg::N_FIELDS];
    logic [NORM_W-1:0]    sq1_reg  [ami_pkg::N_DIM][ami_pkg::N_DIM];
    logic [NORM_W-1:0]    norm2_reg [ami_pkg::N_DIM];
    logic [NORM_W-1:0]    norm_next [ami_pkg::N_DIM];
    logic                 ok2_reg;
    logic                 ok_next;

    for (genvar i = 0; i < ami_pkg::N_FIELDS; i++) begin : g_split
        logic [WORD_BITS-1:0] raw;
        assign raw = in_data[i*WORD_BITS +: WORD_BITS];
        always_ff @(posedge aclk) begin
            if (ld[0]) begin
                neg0_reg[i] <= raw[WORD_BITS-1];
                // most negative word wraps to 2^(W-1), read as unsigned
                mag0_reg[i] <= raw[WORD_BITS-1] ? (~raw + 1'b1) : raw;
            end
            if (ld[1]) begin
                neg1_reg[i] <= neg0_reg[i];
                mag1_reg[i] <= mag0_reg[i];
            end
            if (ld[2]) begin
                neg2_reg[i] <= neg1_reg[i];
                mag2_reg[i] <= mag1_reg[i];
            end
        end
        assign neg_o[i] = neg2_reg[i];
        assign mag_o[i] = mag2_reg[i];
    end

    for (genvar r = 0; r < ami_pkg::N_DIM; r++) begin : g_row
        for (genvar c = 0; c < ami_pkg::N_DIM; c++) begin : g_col
            always_ff @(posedge aclk) begin
                if (ld[1]) begin
                    sq1_reg[r][c] <= NORM_W'(mag0_reg[4*r+c]) * NORM_W'(mag0_reg[4*r+c]);
                end
            end
        end
    end

    always_comb begin
        ok_next = 1'b1;
        for (int k = 0; k < ami_pkg::N_DIM; k++) begin
            norm_next[k] = sq1_reg[0][k] + sq1_reg[1][k] + sq1_reg[2][k];
            if (norm_next[k] <= THR) begin
                ok_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[2]) begin
            norm2_reg <= norm_next;
            ok2_reg   <= ok_next;
        end
    end

    assign norm_o = norm2_reg;
    assign ok_o   = ok2_reg;
endmodule
`default_nettype wire

>>> rtl/ami_div.sv
// Pipelined restoring divider, one quotient bit per stage, with rounding and saturation.
`default_nettype none
module ami_div #(
    parameter int WORD_BITS = ami_pkg::DEF_WORD_BITS,
    parameter int FRAC_BITS = ami_pkg::DEF_FRAC_BITS
) (
    input  wire logic                      aclk,
    input  wire logic [WORD_BITS+2:0]      ld,
    input  wire logic                      neg_i,
    input  wire logic [WORD_BITS-1:0]      mag_i,
    input  wire logic [2*WORD_BITS-1:0]    norm_i,
    output logic                           neg_o,
    output logic [WORD_BITS-1:0]           omag_o,
    output logic [WORD_BITS-1:0]           word_o
);
    localparam int QB     = WORD_BITS + 1;
    localparam int NW     = WORD_BITS + 2*FRAC_BITS;
    localparam int NORM_W = 2*WORD_BITS;
    localparam int CW     = NORM_W + QB + 1;

    logic [NW-1:0]     num;
    logic [NORM_W-1:0] rem_reg [QB+1];
    logic [QB-1:0]     q_reg   [QB+1];
    logic [NORM_W-1:0] d_reg   [QB+1];
    logic [QB-1:0]     lo_reg  [QB+1];
    logic              ovf_reg [QB+1];
    logic              neg_reg [QB+1];

    assign num = {mag_i, {(2*FRAC_BITS){1'b0}}};

    // quotient must fit QB bits, otherwise the result saturates anyway
    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            rem_reg[0] <= NORM_W'(num >> QB);
            q_reg[0]   <= '0;
            d_reg[0]   <= norm_i;
            lo_reg[0]  <= num[QB-1:0];
            ovf_reg[0] <= CW'(num) >= (CW'(norm_i) << QB);
            neg_reg[0] <= neg_i;
        end
    end

    for (genvar i = 1; i <= QB; i++) begin : g_step
        logic [NORM_W:0] trial;
        logic [NORM_W:0] diff;
        logic            take;
        assign trial = {rem_reg[i-1], lo_reg[i-1][QB-i]};
        assign take  = trial >= {1'b0, d_reg[i-1]};
        assign diff  = trial - {1'b0, d_reg[i-1]};
        always_ff @(posedge aclk) begin
            if (ld[i]) begin
                rem_reg[i] <= take ? diff[NORM_W-1:0] : trial[NORM_W-1:0];
                q_reg[i]   <= {q_reg[i-1][QB-2:0], take};
                d_reg[i]   <= d_reg[i-1];
                lo_reg[i]  <= lo_reg[i-1];
                ovf_reg[i] <= ovf_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
            end
        end
    end

    logic              rnd;
    logic [QB:0]       qr;
    logic [QB:0]       lim;
    logic [WORD_BITS-1:0] mag_next;
    logic              neg_out_reg;
    logic [WORD_BITS-1:0] mag_out_reg;
    logic [WORD_BITS-1:0] word_out_reg;

    always_comb begin
        rnd = {rem_reg[QB], 1'b0} >= {1'b0, d_reg[QB]};
        qr  = {1'b0, q_reg[QB]} + (QB+1)'(rnd);
        lim = ((QB+1)'(1) << (WORD_BITS-1)) - (QB+1)'(!neg_reg[QB]);
        mag_next = (ovf_reg[QB] || qr > lim) ? lim[WORD_BITS-1:0] : qr[WORD_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (ld[QB+1]) begin
            neg_out_reg  <= neg_reg[QB];
            mag_out_reg  <= mag_next;
            word_out_reg <= neg_reg[QB] ? (~mag_next + 1'b1) : mag_next;
        end
    end

    assign neg_o  = neg_out_reg;
    assign omag_o = mag_out_reg;
    assign word_o = word_out_reg;
endmodule
`default_nettype wire

>>> rtl/ami_back.sv
// Back stages: inverse translation products, sum, rounding, saturation, identity select.
`default_nettype none
module ami_back #(
    parameter int WORD_BITS = ami_pkg::DEF_WORD_BITS,
    parameter int FRAC_BITS = ami_pkg::DEF_FRAC_BITS
) (
    input  wire logic                                    aclk,
    input  wire logic [ami_pkg::BACK_STAGES-1:0]         ld,
    input  wire logic                                    ok_i,
    input  wire logic                                    lneg_i  [ami_pkg::N_DIM][ami_pkg::N_DIM],
    input  wire logic [WORD_BITS-1:0]                    lmag_i  [ami_pkg::N_DIM][ami_pkg::N_DIM],
    input  wire logic [WORD_BITS-1:0]                    lword_i [ami_pkg::N_DIM][ami_pkg::N_DIM],
    input  wire logic                                    tneg_i  [ami_pkg::N_DIM],
    input  wire logic [WORD_BITS-1:0]                    tmag_i  [ami_pkg::N_DIM],
    output logic [ami_pkg::N_FIELDS*WORD_BITS-1:0]       out_data
);
    localparam int PW = 2*WORD_BITS;
    localparam int SW = 2*WORD_BITS + 2;
    localparam logic [WORD_BITS-1:0] ONE_W = (FRAC_BITS >= WORD_BITS-1) ?
        {1'b0, {(WORD_BITS-1){1'b1}}} : WORD_BITS'(1) << FRAC_BITS;
    localparam logic [SW-1:0] HALF = SW'(1) << (FRAC_BITS-1);

    logic [PW-1:0]        prod0_reg  [ami_pkg::N_DIM][ami_pkg::N_DIM];
    logic                 pneg0_reg  [ami_pkg::N_DIM][ami_pkg::N_DIM];
    logic [WORD_BITS-1:0] lw0_reg    [ami_pkg::N_DIM][ami_pkg::N_DIM];
    logic [WORD_BITS-1:0] lw1_reg    [ami_pkg::N_DIM][ami_pkg::N_DIM];
    logic                 ok0_reg, ok1_reg;
    logic [SW-1:0]        v_next     [ami_pkg::N_DIM];
    logic [SW-1:0]        v1_reg     [ami_pkg::N_DIM];
    logic [ami_pkg::N_FIELDS*WORD_BITS-1:0] out_reg;
    logic [ami_pkg::N_FIELDS*WORD_BITS-1:0] out_next;

    for (genvar k = 0; k < ami_pkg::N_DIM; k++) begin : g_k
        for (genvar i = 0; i < ami_pkg::N_DIM; i++) begin : g_i
            always_ff @(posedge aclk) begin
                if (ld[0]) begin
                    prod0_reg[k][i] <= PW'(lmag_i[k][i]) * PW'(tmag_i[i]);
                    pneg0_reg[k][i] <= lneg_i[k][i] ^ tneg_i[i];
                    lw0_reg[k][i]   <= lword_i[k][i];
                end
                if (ld[1]) begin
                    lw1_reg[k][i]   <= lw0_reg[k][i];
                end
            end
        end
    end

    always_comb begin
        logic [SW-1:0] s;
        for (int k = 0; k < ami_pkg::N_DIM; k++) begin
            s = '0;
            for (int i = 0; i < ami_pkg::N_DIM; i++) begin
                s = pneg0_reg[k][i] ? s - SW'(prod0_reg[k][i]) : s + SW'(prod0_reg[k][i]);
            end
            v_next[k] = ~s + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[0]) ok0_reg <= ok_i;
        if (ld[1]) begin
            ok1_reg <= ok0_reg;
            v1_reg  <= v_next;
        end
    end

    always_comb begin
        logic          vneg;
        logic [SW-1:0] m;
        logic [SW-1:0] lim;
        logic [WORD_BITS-1:0] tm;
        out_next = '0;
        for (int k = 0; k < ami_pkg::N_DIM; k++) begin
            vneg = v1_reg[k][SW-1];
            m    = vneg ? (~v1_reg[k] + 1'b1) : v1_reg[k];
            m    = (m + HALF) >> FRAC_BITS;
            lim  = (SW'(1) << (WORD_BITS-1)) - SW'(!vneg);
            tm   = (m > lim) ? lim[WORD_BITS-1:0] : m[WORD_BITS-1:0];
            for (int i = 0; i < ami_pkg::N_DIM; i++) begin
                out_next[(4*k+i)*WORD_BITS +: WORD_BITS] = ok1_reg ? lw1_reg[k][i] :
                    ((i == k) ? ONE_W : '0);
            end
            out_next[(4*k+3)*WORD_BITS +: WORD_BITS] = !ok1_reg ? '0 :
                (vneg ? (~tm + 1'b1) : tm);
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[2]) out_reg <= out_next;
    end

    assign out_data = out_reg;
endmodule
`default_nettype wire

>>> rtl/affine_matrix_inverse.sv
// Top level: inverse of an orthogonal-scaled 3x4 affine matrix, fully pipelined.
//
//  channel  | direction | handshake               | payload
//  s_axis   | in        | s_axis_tvalid/tready    | 12 words of the matrix, row-major
//  m_axis   | out       | m_axis_tvalid/tready    | 12 words of the inverse, row-major
//
// One transaction per cycle sustained while m_axis_tready stays high; the pipeline depth
// is dominated by the bit-per-stage dividers (WORD_BITS+1 quotient stages).
// Reset clears only the stage valid bits; payload registers are not reset.
// Each stage loads when it is empty or the stage after it loads, so bubbles
// close up behind a stalled output and no transaction is dropped or repeated.
`default_nettype none
module affine_matrix_inverse #(
    parameter int WORD_BITS = ami_pkg::DEF_WORD_BITS,
    parameter int FRAC_BITS = ami_pkg::DEF_FRAC_BITS,
    parameter int DATA_W    = ((ami_pkg::N_FIELDS*WORD_BITS + 7) / 8) * 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // in_r0_c0, in_r0_c1, in_r0_c2, in_r0_c3, in_r1_c0 .. in_r1_c3, in_r2_c0 .. in_r2_c3
    input  wire logic [DATA_W-1:0] s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // out_r0_c0, out_r0_c1, out_r0_c2, out_r0_c3, out_r1_c0 .. out_r1_c3, out_r2_c0 .. out_r2_c3
    output logic [DATA_W-1:0]      m_axis_tdata
);
    localparam int QB      = WORD_BITS + 1;
    localparam int DIV_ST  = QB + 2;
    localparam int DIV0    = ami_pkg::FRONT_STAGES;
    localparam int BACK0   = DIV0 + DIV_ST;
    localparam int NS      = BACK0 + ami_pkg::BACK_STAGES;
    localparam int FW      = ami_pkg::N_FIELDS*WORD_BITS;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS-1:0] ld;

    always_comb begin
        ld[NS-1] = !v_reg[NS-1] || m_axis_tready;
        for (int i = NS-2; i >= 0; i--) begin
            ld[i] = !v_reg[i] || ld[i+1];
        end
        v_next = v_reg;
        if (ld[0]) v_next[0] = s_axis_tvalid;
        for (int i = 1; i < NS; i++) begin
            if (ld[i]) v_next[i] = v_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_axis_tready = ld[0];
    assign m_axis_tvalid = v_reg[NS-1];

    logic                   f_neg  [ami_pkg::N_FIELDS];
    logic [WORD_BITS-1:0]   f_mag  [ami_pkg::N_FIELDS];
    logic [2*WORD_BITS-1:0] f_norm [ami_pkg::N_DIM];
    logic                   f_ok;

    ami_front #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
        .aclk    (aclk),
        .ld      (ld[ami_pkg::FRONT_STAGES-1:0]),
        .in_data (s_axis_tdata[FW-1:0]),
        .neg_o   (f_neg),
        .mag_o   (f_mag),
        .norm_o  (f_norm),
        .ok_o    (f_ok)
    );

    logic                 l_neg  [ami_pkg::N_DIM][ami_pkg::N_DIM];
    logic [WORD_BITS-1:0] l_mag  [ami_pkg::N_DIM][ami_pkg::N_DIM];
    logic [WORD_BITS-1:0] l_word [ami_pkg::N_DIM][ami_pkg::N_DIM];

    // output row k holds input column k, divided by that column's squared norm
    for (genvar k = 0; k < ami_pkg::N_DIM; k++) begin : g_k
        for (genvar i = 0; i < ami_pkg::N_DIM; i++) begin : g_i
            ami_div #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
                .aclk   (aclk),
                .ld     (ld[BACK0-1:DIV0]),
                .neg_i  (f_neg[4*i+k]),
                .mag_i  (f_mag[4*i+k]),
                .norm_i (f_norm[k]),
                .neg_o  (l_neg[k][i]),
                .omag_o (l_mag[k][i]),
                .word_o (l_word[k][i])
            );
        end
    end

    // translation and degenerate flag ride alongside the dividers
    logic                 sd_tneg_reg [DIV_ST][ami_pkg::N_DIM];
    logic [WORD_BITS-1:0] sd_tmag_reg [DIV_ST][ami_pkg::N_DIM];
    logic                 sd_ok_reg   [DIV_ST];

    always_ff @(posedge aclk) begin
        if (ld[DIV0]) begin
            sd_ok_reg[0] <= f_ok;
            for (int r = 0; r < ami_pkg::N_DIM; r++) begin
                sd_tneg_reg[0][r] <= f_neg[4*r+3];
                sd_tmag_reg[0][r] <= f_mag[4*r+3];
            end
        end
        for (int j = 1; j < DIV_ST; j++) begin
            if (ld[DIV0+j]) begin
                sd_ok_reg[j]   <= sd_ok_reg[j-1];
                sd_tneg_reg[j] <= sd_tneg_reg[j-1];
                sd_tmag_reg[j] <= sd_tmag_reg[j-1];
            end
        end
    end

    logic [FW-1:0] out_data;

    ami_back #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .aclk     (aclk),
        .ld       (ld[NS-1:BACK0]),
        .ok_i     (sd_ok_reg[DIV_ST-1]),
        .lneg_i   (l_neg),
        .lmag_i   (l_mag),
        .lword_i  (l_word),
        .tneg_i   (sd_tneg_reg[DIV_ST-1]),
        .tmag_i   (sd_tmag_reg[DIV_ST-1]),
        .out_data (out_data)
    );

    assign m_axis_tdata = DATA_W'(out_data);
endmodule
`default_nettype wire

>>> dv/affine_matrix_inverse_tb.sv
// Testbench for the orthogonal-scaled affine matrix inverse pipeline.
`default_nettype none
module affine_matrix_inverse_tb;

    localparam int WB   = ami_pkg::DEF_WORD_BITS;
    localparam int FB   = ami_pkg::DEF_FRAC_BITS;
    localparam int DW   = ((ami_pkg::N_FIELDS*WB + 7) / 8) * 8;
    localparam int LAT  = WB + 8;

    typedef logic [DW-1:0] mat_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    mat_t s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    mat_t m_axis_tdata;

    mat_t inverse_q[$];
    int   n_errors = 0;
    bit   hold_off = 1'b0;

    affine_matrix_inverse dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

    // Saturate signed value to the word.
    function automatic logic [WB-1:0] sat_word(input logic signed [199:0] v);
        logic signed [199:0] hi, lo;
        hi = (200'sd1 <<< (WB-1)) - 1;
        lo = -(200'sd1 <<< (WB-1));
        if (v > hi) return hi[WB-1:0];
        if (v < lo) return lo[WB-1:0];
        return v[WB-1:0];
    endfunction

    // Round |v| to nearest, ties away from zero, after dropping sh bits.
    function automatic logic signed [199:0] round_away(input logic signed [199:0] v,
                                                      input int sh);
        logic signed [199:0] m;
        m = (v < 0) ? -v : v;
        m = (m + (200'sd1 <<< (sh-1))) >>> sh;
        return (v < 0) ? -m : m;
    endfunction

    function automatic mat_t invert_affine(input mat_t a);
        logic signed [199:0] e[12];
        logic signed [199:0] nrm[3], thr, num, q, r, sum;
        logic [WB-1:0] o[12];
        mat_t res;
        bit ok;
        for (int i = 0; i < 12; i++) e[i] = $signed(a[i*WB +: WB]);
        thr = (200'sd1 <<< (2*FB)) / ami_pkg::THR_DEN;
        ok = 1'b1;
        for (int k = 0; k < 3; k++) begin
            nrm[k] = e[k]*e[k] + e[4+k]*e[4+k] + e[8+k]*e[8+k];
            if (nrm[k] <= thr) ok = 1'b0;
        end
        for (int i = 0; i < 12; i++) o[i] = '0;
        if (!ok) begin
            for (int k = 0; k < 3; k++) o[5*k] = sat_word(200'sd1 <<< FB);
        end else begin
            for (int k = 0; k < 3; k++)
                for (int i = 0; i < 3; i++) begin
                    num = e[4*i+k];
                    num = (num < 0) ? -num : num;
                    num = num <<< (2*FB);
                    q = num / nrm[k];
                    r = num % nrm[k];
                    if (2*r >= nrm[k]) q = q + 1;
                    if (e[4*i+k] < 0) q = -q;
                    o[4*k+i] = sat_word(q);
                end
            for (int k = 0; k < 3; k++) begin
                sum = 0;
                for (int i = 0; i < 3; i++) sum += $signed(o[4*k+i]) * e[4*i+3];
                o[4*k+3] = sat_word(round_away(-sum, FB));
            end
        end
        res = '0;
        for (int i = 0; i < 12; i++) res[i*WB +: WB] = o[i];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int idx,
                                   input logic [WB-1:0] got, input logic [WB-1:0] want);
        n_errors++;
        $display("mismatch %s field %0d: got %h expected %h", what, idx, got, want);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (inverse_q.size() == 0) begin
                report_mismatch("unexpected transaction", 0, m_axis_tdata[WB-1:0], '0);
            end else begin
                mat_t want;
                want = inverse_q.pop_front();
                for (int i = 0; i < 12; i++)
                    if (m_axis_tdata[i*WB +: WB] !== want[i*WB +: WB])
                        report_mismatch("result", i, m_axis_tdata[i*WB +: WB],
                                        want[i*WB +: WB]);
            end
        end
    end

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Receiver: random stalls, plus a long hold-off on request.
    initial begin
        int g;
        @(posedge aclk);
        forever begin
            if (hold_off) begin
                m_axis_tready <= 1'b0;
                for (int c = 0; c < 3*LAT; c++) @(posedge aclk);
                hold_off = 1'b0;
            end
            g = pick_gap();
            if (g > 0) begin
                m_axis_tready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    bit gaps_on = 1'b1;

    task automatic send_matrix(input mat_t a);
        int g;
        g = gaps_on ? pick_gap() : 0;
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= a;
        do @(posedge aclk); while (!s_axis_tready);
        inverse_q.push_back(invert_affine(a));
    endtask

    task automatic idle_input();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic mat_t pack(input logic signed [WB-1:0] v[12]);
        mat_t r;
        r = '0;
        for (int i = 0; i < 12; i++) r[i*WB +: WB] = v[i];
        return r;
    endfunction

    function automatic logic signed [WB-1:0] rnd_word();
        return $urandom();
    endfunction

    // Diagonal/permuted scale matrix with optional sign flips and random translation.
    function automatic mat_t scaled_ortho(input logic signed [WB-1:0] s0,
                                          input logic signed [WB-1:0] s1,
                                          input logic signed [WB-1:0] s2, input bit rot);
        logic signed [WB-1:0] v[12];
        for (int i = 0; i < 12; i++) v[i] = '0;
        if (rot) begin
            v[1] = s0; v[6] = s1; v[8] = s2;
        end else begin
            v[0] = s0; v[5] = s1; v[10] = s2;
        end
        v[3] = rnd_word() >>> $urandom_range(0, 31);
        v[7] = rnd_word() >>> $urandom_range(0, 31);
        v[11] = rnd_word() >>> $urandom_range(0, 31);
        return pack(v);
    endfunction

    task automatic test_directed();
        logic signed [WB-1:0] v[12];
        logic signed [WB-1:0] one, mx, mn;
        one = 1 <<< FB;
        mx = {1'b0, {(WB-1){1'b1}}};
        mn = {1'b1, {(WB-1){1'b0}}};
        send_matrix('0);                                   // all zero: identity
        send_matrix(scaled_ortho(one, one, one, 1'b0));    // plain identity with shift
        send_matrix(scaled_ortho(mx, mx, mx, 1'b0));       // huge scale
        send_matrix(scaled_ortho(mn, mn, mn, 1'b0));       // most negative
        send_matrix(scaled_ortho(1, one, one, 1'b0));      // tiny: below threshold
        send_matrix(scaled_ortho(655, 655, 655, 1'b0));    // norm just below threshold
        send_matrix(scaled_ortho(656, 656, 656, 1'b0));    // norm just above threshold
        send_matrix(scaled_ortho(-656, 656, -656, 1'b1));
        send_matrix(scaled_ortho(656, -656, 656, 1'b0));   // smallest usable scale
        send_matrix(scaled_ortho(one/2, -2*one, 3*one, 1'b1));
        for (int i = 0; i < 12; i++) v[i] = mx;
        send_matrix(pack(v));                              // non-orthogonal extremes
        for (int i = 0; i < 12; i++) v[i] = mn;
        send_matrix(pack(v));
        for (int i = 0; i < 12; i++) v[i] = (i % 2) ? mx : mn;
        send_matrix(pack(v));
        for (int i = 0; i < 12; i++) v[i] = -1;
        send_matrix(pack(v));
        idle_input();
    endtask

    task automatic test_random(input int n);
        logic signed [WB-1:0] v[12];
        int kind;
        for (int t = 0; t < n; t++) begin
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                send_matrix(scaled_ortho(rnd_word() >>> $urandom_range(0, 28),
                                         rnd_word() >>> $urandom_range(0, 28),
                                         rnd_word() >>> $urandom_range(0, 28),
                                         $urandom_range(0, 1)));
            end else if (kind < 8) begin
                for (int i = 0; i < 12; i++) v[i] = rnd_word() >>> $urandom_range(0, 31);
                send_matrix(pack(v));
            end else begin
                for (int i = 0; i < 12; i++) v[i] = rnd_word();
                send_matrix(pack(v));
            end
        end
        idle_input();
    endtask

    // Long output stall while input keeps streaming back to back.
    task automatic test_backpressure();
        gaps_on = 1'b0;
        hold_off = 1'b1;
        test_random(2*LAT);
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_random(600);
        while (inverse_q.size() != 0) @(posedge aclk);
        repeat (LAT + 10) @(posedge aclk);
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire

>>> filelist.f
rtl/ami_pkg.sv
rtl/ami_front.sv
rtl/ami_div.sv
rtl/ami_back.sv
rtl/affine_matrix_inverse.sv
dv/affine_matrix_inverse_tb.sv
